// ----- hdl/gpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared types, constants and the pin event function of the GPIO controller.
// ----------------------------------------------------------------------------
package gpc_pkg;

    localparam int DEF_NUM_BANKS      = 8;
    localparam int DEF_PORTS_PER_BANK = 4;
    localparam int PINS_PER_PORT      = 8;

    // slot of port (b,p) is b*PORT_STRIDE+p, whatever the bank size
    localparam int PORT_STRIDE = 4;
    localparam int BANK_W      = 3;
    localparam int PORT_W      = 2;
    localparam int SLOT_W      = BANK_W + PORT_W;
    localparam int BANK_IRQ_W  = 8;
    localparam int DATA_W      = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DATA_W-1:0] LVL_FIELD_MASK = 24'h010101;
    localparam logic [DATA_W-1:0] LVL_RISING     = 24'h000101;
    localparam logic [DATA_W-1:0] LVL_FALLING    = 24'h000100;
    localparam logic [DATA_W-1:0] LVL_BOTH       = 24'h010100;
    localparam logic [DATA_W-1:0] LVL_HIGH       = 24'h000001;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_MASKED = 2'd2,
        OP_SAMPLE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        SEL_CNF = 3'd0,
        SEL_OE  = 3'd1,
        SEL_OUT = 3'd2,
        SEL_IN  = 3'd3,
        SEL_STA = 3'd4,
        SEL_ENB = 3'd5,
        SEL_LVL = 3'd6,
        SEL_CLR = 3'd7
    } reg_sel_t;

    // what the back end does with a classified transfer
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_READ,
        ACT_WRITE,
        ACT_MASKED,
        ACT_CLEAR,
        ACT_SAMPLE
    } action_t;

    typedef struct packed {
        action_t                  action;
        logic                     err;
        reg_sel_t                 sel;
        logic [SLOT_W-1:0]        slot;
        logic [DATA_W-1:0]        wdata;
        logic [PINS_PER_PORT-1:0] pins;
    } cmd_t;

    function automatic logic [PINS_PER_PORT-1:0] pin_hits(
        input logic [DATA_W-1:0]        lvl,
        input logic [PINS_PER_PORT-1:0] prev,
        input logic [PINS_PER_PORT-1:0] now
    );
        logic [PINS_PER_PORT-1:0] hits;
        logic [DATA_W-1:0]        kind;
        hits = '0;
        for (int i = 0; i < PINS_PER_PORT; i++)
        begin
            kind = (lvl >> i) & LVL_FIELD_MASK;
            if ((kind & LVL_FALLING) == '0)
                hits[i] = ((kind & LVL_HIGH) != '0) ? now[i] : !now[i];
            else if ((kind & LVL_BOTH) == LVL_BOTH)
                hits[i] = prev[i] ^ now[i];
            else if ((kind & LVL_RISING) == LVL_RISING)
                hits[i] = !prev[i] && now[i];
            else
                hits[i] = prev[i] && !now[i];
        end
        return hits;
    endfunction

endpackage

// ----- hdl/gpc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpc_front
// Classifies each incoming transfer into a command for the back end.
// ----------------------------------------------------------------------------
module gpc_front #(
    parameter int NUM_BANKS      = gpc_pkg::DEF_NUM_BANKS,
    parameter int PORTS_PER_BANK = gpc_pkg::DEF_PORTS_PER_BANK
) (
    input  logic [1:0]                         operation,
    input  logic [gpc_pkg::BANK_W-1:0]         bank,
    input  logic [gpc_pkg::PORT_W-1:0]         port,
    input  logic [2:0]                         reg_select,
    input  logic [gpc_pkg::DATA_W-1:0]         write_data,
    input  logic [gpc_pkg::PINS_PER_PORT-1:0]  pin_levels,
    output gpc_pkg::cmd_t                      cmd
);
    import gpc_pkg::*;

    op_t      op;
    reg_sel_t sel;
    logic     range_err;
    action_t  action;
    logic     reg_err;

    assign op  = op_t'(operation);
    assign sel = reg_sel_t'(reg_select);
    assign range_err = (32'(bank) >= NUM_BANKS) || (32'(port) >= PORTS_PER_BANK);

    always_comb
    begin
        action  = ACT_NONE;
        reg_err = 1'b0;
        case (op)
            OP_READ:
            begin
                if (sel == SEL_CLR)
                    reg_err = 1'b1;
                else
                    action = ACT_READ;
            end
            OP_WRITE:
            begin
                if (sel == SEL_IN)
                    reg_err = 1'b1;
                else if (sel == SEL_CLR)
                    action = ACT_CLEAR;
                else
                    action = ACT_WRITE;
            end
            OP_MASKED:
            begin
                if (sel inside {SEL_CNF, SEL_OE, SEL_OUT, SEL_ENB})
                    action = ACT_MASKED;
                else
                    reg_err = 1'b1;
            end
            OP_SAMPLE: action = ACT_SAMPLE;
            default:   reg_err = 1'b1;
        endcase
    end

    always_comb
    begin
        cmd.action = range_err ? ACT_NONE : action;
        cmd.err    = range_err || reg_err;
        cmd.sel    = sel;
        cmd.slot   = {bank, port};
        cmd.wdata  = write_data;
        cmd.pins   = pin_levels;
    end

endmodule

// ----- hdl/gpc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpc_queue
// Short command queue between the classifier and the execution back end.
// ----------------------------------------------------------------------------
module gpc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gpc_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output gpc_pkg::cmd_t head_cmd
);
    import gpc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (32'(count_reg) == QUEUE_DEPTH);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- hdl/gpc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpc_back
// Port register file; one command per cycle, unless stalled, into output regs.
// ----------------------------------------------------------------------------
module gpc_back #(
    parameter int NUM_BANKS      = gpc_pkg::DEF_NUM_BANKS,
    parameter int PORTS_PER_BANK = gpc_pkg::DEF_PORTS_PER_BANK
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  gpc_pkg::cmd_t                     cmd,
    output logic                              cmd_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [gpc_pkg::DATA_W-1:0]        read_data,
    output logic [gpc_pkg::BANK_IRQ_W-1:0]    bank_irq,
    output logic                              access_error
);
    import gpc_pkg::*;

    localparam int NUM_SLOTS = NUM_BANKS * PORT_STRIDE;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int PW        = PINS_PER_PORT;

    logic [PW-1:0]     mode_reg [NUM_SLOTS];
    logic [PW-1:0]     oe_reg   [NUM_SLOTS];
    logic [PW-1:0]     out_reg  [NUM_SLOTS];
    logic [PW-1:0]     in_reg   [NUM_SLOTS];
    logic [PW-1:0]     sta_reg  [NUM_SLOTS];
    logic [PW-1:0]     enb_reg  [NUM_SLOTS];
    logic [DATA_W-1:0] lvl_reg  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] pend_reg, pend_next;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     rdata_reg;
    logic [BANK_IRQ_W-1:0] irq_reg, irq_next;
    logic                  err_reg;

    logic              exec;
    logic              live;
    logic [IDX_W-1:0]  idx;
    logic [PW-1:0]     byte_cur, byte_new, mask;
    logic [PW-1:0]     sta_new, enb_new;
    logic [DATA_W-1:0] rdata;
    logic              we_byte, we_sta, we_lvl, we_in;

    assign exec    = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_pop = exec;
    assign live    = (cmd.action != ACT_NONE);
    assign idx     = cmd.slot[IDX_W-1:0];
    assign mask    = cmd.wdata[2*PW-1:PW];

    always_comb
    begin
        case (cmd.sel)
            SEL_CNF: byte_cur = mode_reg[idx];
            SEL_OE:  byte_cur = oe_reg[idx];
            SEL_OUT: byte_cur = out_reg[idx];
            SEL_ENB: byte_cur = enb_reg[idx];
            default: byte_cur = '0;
        endcase
    end

    always_comb
    begin
        rdata    = '0;
        byte_new = byte_cur;
        sta_new  = sta_reg[idx];
        we_byte  = 1'b0;
        we_sta   = 1'b0;
        we_lvl   = 1'b0;
        we_in    = 1'b0;
        case (cmd.action)
            ACT_READ:
            begin
                case (cmd.sel)
                    SEL_IN:  rdata = DATA_W'(in_reg[idx]);
                    SEL_STA: rdata = DATA_W'(sta_reg[idx]);
                    SEL_LVL: rdata = lvl_reg[idx];
                    default: rdata = DATA_W'(byte_cur);
                endcase
            end
            ACT_WRITE:
            begin
                if (cmd.sel == SEL_STA)
                begin
                    sta_new = cmd.wdata[PW-1:0];
                    we_sta  = 1'b1;
                end
                else if (cmd.sel == SEL_LVL)
                    we_lvl = 1'b1;
                else
                begin
                    byte_new = cmd.wdata[PW-1:0];
                    we_byte  = 1'b1;
                end
            end
            ACT_MASKED:
            begin
                byte_new = (byte_cur & ~mask) | (cmd.wdata[PW-1:0] & mask);
                we_byte  = 1'b1;
            end
            ACT_CLEAR:
            begin
                sta_new = sta_reg[idx] & ~cmd.wdata[PW-1:0];
                we_sta  = 1'b1;
            end
            ACT_SAMPLE:
            begin
                sta_new = sta_reg[idx] | pin_hits(lvl_reg[idx], in_reg[idx], cmd.pins);
                we_sta  = 1'b1;
                we_in   = 1'b1;
            end
            default: ;
        endcase
    end

    assign enb_new = (we_byte && cmd.sel == SEL_ENB) ? byte_new : enb_reg[idx];

    always_comb
    begin
        pend_next = pend_reg;
        if (live)
            pend_next[idx] = |(sta_new & enb_new);
    end

    genvar gb;
    generate
        for (gb = 0; gb < BANK_IRQ_W; gb++)
        begin : g_irq
            if (gb < NUM_BANKS)
            begin : g_live
                assign irq_next[gb] =
                    |pend_next[gb*PORT_STRIDE +: PORTS_PER_BANK];
            end
            else
            begin : g_none
                assign irq_next[gb] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                mode_reg[s] <= '0;
                oe_reg[s]   <= '0;
                out_reg[s]  <= '0;
                in_reg[s]   <= '0;
                sta_reg[s]  <= '0;
                enb_reg[s]  <= '0;
                lvl_reg[s]  <= '0;
            end
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (exec && live)
            begin
                pend_reg <= pend_next;
                if (we_byte)
                begin
                    case (cmd.sel)
                        SEL_CNF: mode_reg[idx] <= byte_new;
                        SEL_OE:  oe_reg[idx]   <= byte_new;
                        SEL_OUT: out_reg[idx]  <= byte_new;
                        SEL_ENB: enb_reg[idx]  <= byte_new;
                        default: ;
                    endcase
                end
                if (we_sta)
                    sta_reg[idx] <= sta_new;
                if (we_lvl)
                    lvl_reg[idx] <= cmd.wdata;
                if (we_in)
                    in_reg[idx] <= cmd.pins;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            rdata_reg <= rdata;
            irq_reg   <= irq_next;
            err_reg   <= cmd.err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rdata_reg;
    assign bank_irq     = irq_reg;
    assign access_error = err_reg;

endmodule

// ----- hdl/gpio_port_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_port_controller
// GPIO controller: banks of 8-pin ports with masked writes and pin interrupts.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | operation bank port reg_select write_data
//          |                      | pin_levels
//  out     | out_valid / out_ready| read_data bank_irq access_error
//
//  A transfer is classified, queued (two entries), then executed by the port
//  register file, which writes its result into the output register.
//  One transfer per cycle sustained while the output is not stalled; the
//  read-modify-write of the selected port sets that figure. Reset clears
//  every port register. A stalled output fills the queue, after which
//  in_ready drops.
// ----------------------------------------------------------------------------
module gpio_port_controller #(
    parameter int NUM_BANKS      = gpc_pkg::DEF_NUM_BANKS,
    parameter int PORTS_PER_BANK = gpc_pkg::DEF_PORTS_PER_BANK
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic [gpc_pkg::BANK_W-1:0]         bank,
    input  logic [gpc_pkg::PORT_W-1:0]         port,
    input  logic [2:0]                         reg_select,
    input  logic [gpc_pkg::DATA_W-1:0]         write_data,
    input  logic [gpc_pkg::PINS_PER_PORT-1:0]  pin_levels,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gpc_pkg::DATA_W-1:0]         read_data,
    output logic [gpc_pkg::BANK_IRQ_W-1:0]     bank_irq,
    output logic                               access_error
);
    import gpc_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic q_not_empty;
    logic q_pop;

    assign in_ready = !q_full;

    gpc_front #(
        .NUM_BANKS      (NUM_BANKS),
        .PORTS_PER_BANK (PORTS_PER_BANK)
    ) u_front (
        .operation  (operation),
        .bank       (bank),
        .port       (port),
        .reg_select (reg_select),
        .write_data (write_data),
        .pin_levels (pin_levels),
        .cmd        (front_cmd)
    );

    gpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    gpc_back #(
        .NUM_BANKS      (NUM_BANKS),
        .PORTS_PER_BANK (PORTS_PER_BANK)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_not_empty),
        .cmd          (head_cmd),
        .cmd_pop      (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .bank_irq     (bank_irq),
        .access_error (access_error)
    );

endmodule
